/* rtl/sblf_pkg.sv */
// ----------------------------------------------------------------------------
// sblf_pkg
// Shared constants and types for the sparse bitmap leaf set unit.
// ----------------------------------------------------------------------------
package sblf_pkg;

  localparam int PACKED_DEPTH = 64;
  localparam int CNT_W        = $clog2(PACKED_DEPTH + 1);
  localparam int KEY_W        = 10;
  localparam int WORD_W       = 64;
  localparam int BIT_SHIFT    = 6;
  localparam int ID_W         = KEY_W + BIT_SHIFT;
  localparam int DENSE_WORDS  = 1024;
  localparam int DENSE_AW     = $clog2(DENSE_WORDS);
  localparam int LIMIT_W      = 6;
  localparam int GRP          = 8;
  localparam int NGRP         = (PACKED_DEPTH + GRP - 1) / GRP;

  // Cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SETBIT = 2'd2;
  localparam logic [1:0] OP_SHIFT  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] bitw;
  } cell_ctl_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] word;
    logic              lt;
    logic              open;
  } cell_link_t;

endpackage

/* rtl/sblf_ram.sv */
// ----------------------------------------------------------------------------
// sblf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sblf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sblf_cell.sv */
// ----------------------------------------------------------------------------
// sblf_cell
// One packed entry: a key and its word, linked to both neighbours.
// ----------------------------------------------------------------------------
module sblf_cell (
  input  logic                      clk,
  input  sblf_pkg::cell_ctl_t       ctl,
  input  logic                      occ,
  input  sblf_pkg::cell_link_t      left,
  input  sblf_pkg::cell_link_t      right,
  output sblf_pkg::cell_link_t      link,
  output logic                      eq
);

  logic [sblf_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [sblf_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                        lt;

  assign lt = occ && (key_r < ctl.key);
  assign eq = occ && (key_r == ctl.key);

  assign link.key  = key_r;
  assign link.word = word_r;
  assign link.lt   = lt;
  assign link.open = occ && !lt;

  always_comb begin
    key_nxt  = key_r;
    word_nxt = word_r;
    case (ctl.op)
      sblf_pkg::OP_INSERT: begin
        // Entries at or after the insert point move one place up.
        if (left.open) begin
          key_nxt  = left.key;
          word_nxt = left.word;
        end else if (left.lt && !lt) begin
          key_nxt  = ctl.key;
          word_nxt = ctl.bitw;
        end
      end
      sblf_pkg::OP_SETBIT: begin
        if (eq) begin
          word_nxt = word_r | ctl.bitw;
        end
      end
      sblf_pkg::OP_SHIFT: begin
        key_nxt  = right.key;
        word_nxt = right.word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    word_r <= word_nxt;
  end

endmodule

/* rtl/sparse_bitmap_leaf_set_unit.sv */
// ----------------------------------------------------------------------------
// sparse_bitmap_leaf_set_unit
// Sets one bit in a bitmap leaf held as a sorted packed list or a dense store.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Signals                         | Handshake
//   --------+-----------+---------------------------------+---------------
//   in      | input     | in_doc_id                       | valid / stall
//   out     | output    | out_dense_mode, out_entries_used,| valid / stall
//           |           | out_word_after                  |
//   cfg     | input     | cfg_packed_limit                | valid / ready
//
// A packed-mode transfer passes from acceptance through the registered match
// tree over the cell row (flags, groups, final word), then the update of the
// row and the load of the result register. A dense-mode transfer passes
// through the registered read of the dense RAM, its write back and the
// load of the result register.
// The conversion to dense mode shifts the row out of its first cell into the
// RAM one packed entry at a time, and then writes the new bit at its key.
// After reset the dense RAM is cleared one word per cycle, during which no
// input transfer is accepted; configuration writes are always taken.
// A result that is stalled holds the unit in its final state until it drains.
//
module sparse_bitmap_leaf_set_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sblf_pkg::ID_W-1:0]           in_doc_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_dense_mode,
  output logic [sblf_pkg::CNT_W-1:0]          out_entries_used,
  output logic [sblf_pkg::WORD_W-1:0]         out_word_after,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sblf_pkg::LIMIT_W-1:0]        cfg_packed_limit
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_LOOK = 4'd2;
  localparam logic [3:0] ST_RED1 = 4'd3;
  localparam logic [3:0] ST_DEC  = 4'd4;
  localparam logic [3:0] ST_CONV = 4'd5;
  localparam logic [3:0] ST_DRD  = 4'd6;
  localparam logic [3:0] ST_DWR  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;
  localparam logic [3:0] ST_RED2 = 4'd9;

  localparam int D = sblf_pkg::PACKED_DEPTH;

  logic [3:0]                       state_r, state_nxt;
  logic                             mode_r, mode_nxt;
  logic [sblf_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [sblf_pkg::LIMIT_W-1:0]     limit_r;
  logic [sblf_pkg::DENSE_AW-1:0]    clr_r, clr_nxt;
  logic [sblf_pkg::KEY_W-1:0]       key_r;
  logic [sblf_pkg::WORD_W-1:0]      bit_r;
  logic                             res_mode_r, res_mode_nxt;
  logic [sblf_pkg::CNT_W-1:0]       res_cnt_r, res_cnt_nxt;
  logic [sblf_pkg::WORD_W-1:0]      res_word_r, res_word_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_mode_r;
  logic [sblf_pkg::CNT_W-1:0]       out_cnt_r;
  logic [sblf_pkg::WORD_W-1:0]      out_word_r;

  // Match tree registers
  logic [D-1:0]                     eq_r;
  logic [sblf_pkg::WORD_W-1:0]      grp_word_r [sblf_pkg::NGRP];
  logic [sblf_pkg::NGRP-1:0]        grp_hit_r;
  logic [sblf_pkg::WORD_W-1:0]      hit_word_r;
  logic                             hit_r;

  sblf_pkg::cell_ctl_t              ctl;
  sblf_pkg::cell_link_t             links [D];
  sblf_pkg::cell_link_t             left_in [D];
  sblf_pkg::cell_link_t             right_in [D];
  logic [D-1:0]                     eq_v;
  logic [D-1:0]                     occ_v;

  logic                             ram_we;
  logic [sblf_pkg::DENSE_AW-1:0]    ram_waddr;
  logic [sblf_pkg::WORD_W-1:0]      ram_wdata;
  logic [sblf_pkg::WORD_W-1:0]      ram_rdata;

  logic                             in_xfer;
  logic                             out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_dense_mode   = out_mode_r;
  assign out_entries_used = out_cnt_r;
  assign out_word_after   = out_word_r;

  // The cell row. Cell 0 sees a left neighbour that is always below the key,
  // the last cell a right neighbour that is never read into a valid place.
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign occ_v[i] = (sblf_pkg::CNT_W'(i) < cnt_r);
    if (i == 0) begin : g_first
      assign left_in[i] = '{key: '0, word: '0, lt: 1'b1, open: 1'b0};
    end else begin : g_mid
      assign left_in[i] = links[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_in[i] = '{key: '0, word: '0, lt: 1'b0, open: 1'b0};
    end else begin : g_inner
      assign right_in[i] = links[i+1];
    end
    sblf_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .occ   (occ_v[i]),
      .left  (left_in[i]),
      .right (right_in[i]),
      .link  (links[i]),
      .eq    (eq_v[i])
    );
  end

  sblf_ram #(
    .WIDTH (sblf_pkg::WORD_W),
    .DEPTH (sblf_pkg::DENSE_WORDS)
  ) u_dense (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (key_r),
    .rdata (ram_rdata)
  );

  // Registered match tree: flags, then groups of eight, then the final word.
  always_ff @(posedge clk) begin
    eq_r <= eq_v;
    for (int g = 0; g < sblf_pkg::NGRP; g++) begin
      grp_word_r[g] <= '0;
      grp_hit_r[g]  <= 1'b0;
      for (int j = 0; j < sblf_pkg::GRP; j++) begin
        if (g * sblf_pkg::GRP + j < D) begin
          if (eq_r[g * sblf_pkg::GRP + j]) begin
            grp_word_r[g] <= links[g * sblf_pkg::GRP + j].word;
            grp_hit_r[g]  <= 1'b1;
          end
        end
      end
    end
    hit_word_r <= '0;
    for (int g = 0; g < sblf_pkg::NGRP; g++) begin
      if (grp_hit_r[g]) begin
        hit_word_r <= grp_word_r[g];
      end
    end
    hit_r <= |grp_hit_r;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    res_mode_nxt  = res_mode_r;
    res_cnt_nxt   = res_cnt_r;
    res_word_nxt  = res_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.op        = sblf_pkg::OP_HOLD;
    ctl.key       = key_r;
    ctl.bitw      = bit_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;

    case (state_r)
      ST_CLR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = mode_r ? ST_DRD : ST_LOOK;
        end
      end
      ST_LOOK: state_nxt = ST_RED1;
      ST_RED1: state_nxt = ST_RED2;
      ST_RED2: state_nxt = ST_DEC;
      ST_DEC: begin
        if (hit_r) begin
          ctl.op       = sblf_pkg::OP_SETBIT;
          res_mode_nxt = 1'b0;
          res_cnt_nxt  = cnt_r;
          res_word_nxt = hit_word_r | bit_r;
          state_nxt    = ST_FIN;
        end else if (cnt_r > {1'b0, limit_r} || cnt_r == sblf_pkg::CNT_W'(D)) begin
          state_nxt = ST_CONV;
        end else begin
          ctl.op       = sblf_pkg::OP_INSERT;
          cnt_nxt      = cnt_r + 1'b1;
          res_mode_nxt = 1'b0;
          res_cnt_nxt  = cnt_r + 1'b1;
          res_word_nxt = bit_r;
          state_nxt    = ST_FIN;
        end
      end
      ST_CONV: begin
        // Drain the row through its first cell; the new key is absent, so its
        // dense word is just the new bit.
        ram_we = 1'b1;
        if (cnt_r != '0) begin
          ctl.op    = sblf_pkg::OP_SHIFT;
          ram_waddr = links[0].key;
          ram_wdata = links[0].word;
          cnt_nxt   = cnt_r - 1'b1;
        end else begin
          ram_waddr    = key_r;
          ram_wdata    = bit_r;
          mode_nxt     = 1'b1;
          res_mode_nxt = 1'b1;
          res_cnt_nxt  = '0;
          res_word_nxt = bit_r;
          state_nxt    = ST_FIN;
        end
      end
      ST_DRD: state_nxt = ST_DWR;
      ST_DWR: begin
        ram_we       = 1'b1;
        ram_waddr    = key_r;
        ram_wdata    = ram_rdata | bit_r;
        res_mode_nxt = 1'b1;
        res_cnt_nxt  = '0;
        res_word_nxt = ram_rdata | bit_r;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      mode_r      <= 1'b0;
      cnt_r       <= '0;
      clr_r       <= '0;
      limit_r     <= sblf_pkg::LIMIT_W'(32);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_packed_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_mode_r <= res_mode_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_word_r <= res_word_nxt;
    if (in_xfer) begin
      key_r <= in_doc_id[sblf_pkg::ID_W-1:sblf_pkg::BIT_SHIFT];
      bit_r <= sblf_pkg::WORD_W'(1) << in_doc_id[sblf_pkg::BIT_SHIFT-1:0];
    end
    if (state_r == ST_FIN && out_free) begin
      out_mode_r <= res_mode_r;
      out_cnt_r  <= res_cnt_r;
      out_word_r <= res_word_r;
    end
  end

endmodule

/* rtl/sblf_checker.sv */
// ----------------------------------------------------------------------------
// sblf_checker
// Port-level checks for the sparse bitmap leaf set unit.
// ----------------------------------------------------------------------------
module sblf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_dense_mode,
  input logic [sblf_pkg::CNT_W-1:0]    out_entries_used,
  input logic [sblf_pkg::WORD_W-1:0]   out_word_after
);

  // A stalled result is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_after))
    else $error("stalled result changed");

  a_dense_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dense_mode |-> out_entries_used == '0)
    else $error("entry count non-zero in dense mode");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dense_mode |-> out_entries_used <= sblf_pkg::CNT_W'(sblf_pkg::PACKED_DEPTH)
      && out_entries_used != '0)
    else $error("entry count out of range");

  // Dense mode is kept until reset.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_dense_mode |=> !out_valid || out_dense_mode)
    else $error("left dense mode");

  // The word holding the id always has at least its bit set.
  a_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_after != '0)
    else $error("empty result word");

endmodule

bind sparse_bitmap_leaf_set_unit sblf_checker u_sblf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_dense_mode   (out_dense_mode),
  .out_entries_used (out_entries_used),
  .out_word_after   (out_word_after)
);

/* tb/sv/sparse_bitmap_leaf_set_unit_tb.sv */
// ----------------------------------------------------------------------------
// sparse_bitmap_leaf_set_unit_tb
// Self-checking bench for the bitmap leaf set unit.
// A short table of directed ids is sent first. Then a packed phase fills the
// sorted list to its depth and forces the move to the dense store. A long
// dense phase follows. Every result is compared field by field with its typed
// table row or else with a behavioural copy of the leaf kept in the bench.
// Both sides idle and stall at random in several phases, and the limit
// register is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_bitmap_leaf_set_unit_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 240;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    bit                        dense;
    bit [sblf_pkg::CNT_W-1:0]  used;
    bit [sblf_pkg::WORD_W-1:0] word;
  } leaf_result_t;

  typedef struct {
    bit [sblf_pkg::ID_W-1:0]   id;
    bit                        typed;
    bit                        dense;
    bit [sblf_pkg::CNT_W-1:0]  used;
    bit [sblf_pkg::WORD_W-1:0] word;
  } id_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [sblf_pkg::ID_W-1:0]     in_doc_id;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_dense_mode;
  logic [sblf_pkg::CNT_W-1:0]    out_entries_used;
  logic [sblf_pkg::WORD_W-1:0]   out_word_after;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sblf_pkg::LIMIT_W-1:0]  cfg_packed_limit;

  // Bench copy of the leaf state.
  bit [sblf_pkg::LIMIT_W-1:0] leaf_limit;
  bit                         leaf_dense;
  int                         leaf_count;
  bit [sblf_pkg::KEY_W-1:0]   leaf_keys [sblf_pkg::PACKED_DEPTH];
  bit [sblf_pkg::WORD_W-1:0]  leaf_words [sblf_pkg::PACKED_DEPTH];
  bit [sblf_pkg::WORD_W-1:0]  dense_store [sblf_pkg::DENSE_WORDS];

  leaf_result_t pending_results[$];

  int  errors;
  int  results_seen;
  int  ids_sent;
  int  idle_mode;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  bit  hold_request;
  int  hold_left;
  int  quiet_cycles;
  bit  moved_dense;

  sparse_bitmap_leaf_set_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_doc_id        (in_doc_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dense_mode   (out_dense_mode),
    .out_entries_used (out_entries_used),
    .out_word_after   (out_word_after),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_packed_limit (cfg_packed_limit)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Directed ids. Rows with typed results start from reset with a limit of 32.
  id_row_t id_table [] = '{
    '{16'h0000, 1, 0, 7'd1, 64'h0000_0000_0000_0001},
    '{16'hFFFF, 1, 0, 7'd2, 64'h8000_0000_0000_0000},
    '{16'h003F, 1, 0, 7'd2, 64'h8000_0000_0000_0001},
    '{16'hFFC0, 1, 0, 7'd2, 64'h8000_0000_0000_0001},
    '{16'h8000, 1, 0, 7'd3, 64'h0000_0000_0000_0001},
    '{16'h0040, 1, 0, 7'd4, 64'h0000_0000_0000_0001},
    '{16'h7FFF, 0, 0, 7'd0, 64'h0},
    '{16'h5555, 0, 0, 7'd0, 64'h0},
    '{16'hAAAA, 0, 0, 7'd0, 64'h0},
    '{16'h8001, 0, 0, 7'd0, 64'h0},
    '{16'h0041, 0, 0, 7'd0, 64'h0},
    '{16'h7FC0, 0, 0, 7'd0, 64'h0},
    '{16'h0020, 0, 0, 7'd0, 64'h0},
    '{16'hFFFE, 0, 0, 7'd0, 64'h0}
  };

  function automatic bit key_is_packed(input bit [sblf_pkg::KEY_W-1:0] key);
    for (int i = 0; i < leaf_count; i++) begin
      if (leaf_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Sets the bit for one id in the bench copy and returns what the unit should
  // report for it.
  function automatic leaf_result_t set_leaf_bit(input bit [sblf_pkg::ID_W-1:0] id);
    leaf_result_t              r;
    bit [sblf_pkg::KEY_W-1:0]  key;
    bit [sblf_pkg::WORD_W-1:0] bitw;
    int                        pos;
    key  = id[sblf_pkg::ID_W-1:sblf_pkg::BIT_SHIFT];
    bitw = 64'd1 << id[sblf_pkg::BIT_SHIFT-1:0];
    if (leaf_dense) begin
      dense_store[key] |= bitw;
      r.word = dense_store[key];
    end else begin
      pos = 0;
      while (pos < leaf_count && leaf_keys[pos] < key) pos++;
      if (pos < leaf_count && leaf_keys[pos] == key) begin
        leaf_words[pos] |= bitw;
        r.word = leaf_words[pos];
      end else if (leaf_count > leaf_limit || leaf_count >= sblf_pkg::PACKED_DEPTH) begin
        // Conversion: the store is cleared, every packed word lands at its
        // own key and the new bit is then added at its key.
        for (int i = 0; i < sblf_pkg::DENSE_WORDS; i++) dense_store[i] = '0;
        for (int i = 0; i < leaf_count; i++) dense_store[leaf_keys[i]] = leaf_words[i];
        dense_store[key] |= bitw;
        r.word     = dense_store[key];
        leaf_count = 0;
        leaf_dense = 1'b1;
        moved_dense = 1'b1;
      end else begin
        for (int i = leaf_count; i > pos; i--) begin
          leaf_keys[i]  = leaf_keys[i-1];
          leaf_words[i] = leaf_words[i-1];
        end
        leaf_keys[pos]  = key;
        leaf_words[pos] = bitw;
        leaf_count++;
        r.word = bitw;
      end
    end
    r.dense = leaf_dense;
    r.used  = leaf_dense ? '0 : sblf_pkg::CNT_W'(leaf_count);
    return r;
  endfunction

  task automatic report_mismatch(input string field,
                                 input bit [sblf_pkg::WORD_W-1:0] got,
                                 input bit [sblf_pkg::WORD_W-1:0] want);
    $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, field, got, want);
    errors++;
  endtask

  // One id transfer. The predictor runs at acceptance so that the order of
  // expectations follows the order of transfers.
  task automatic send_id(input bit [sblf_pkg::ID_W-1:0] id, input bit typed,
                         input leaf_result_t typed_result);
    leaf_result_t r;
    in_valid  <= 1'b1;
    in_doc_id <= id;
    do @(posedge clk); while (in_stall);
    r = set_leaf_bit(id);
    pending_results.insert(pending_results.size(), typed ? typed_result : r);
    ids_sent++;
    if ((idle_mode == 1 && $urandom_range(99) < 66) ||
        (idle_mode == 3 && $urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // The limit is only written once every result has come back.
  task automatic write_limit(input bit [sblf_pkg::LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_packed_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    leaf_limit = value;
  endtask

  function automatic bit [sblf_pkg::ID_W-1:0] fresh_id();
    bit [sblf_pkg::KEY_W-1:0] key;
    do key = sblf_pkg::KEY_W'($urandom_range(sblf_pkg::DENSE_WORDS - 1));
    while (key_is_packed(key));
    return {key, sblf_pkg::BIT_SHIFT'($urandom)};
  endfunction

  // Result side: checks each transfer and draws the stall for the next cycle.
  always @(posedge clk) begin
    leaf_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("UNEXPECTED result %0d: nothing was waiting", results_seen);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_dense_mode != want.dense)
          report_mismatch("dense_mode", out_dense_mode, want.dense);
        if (out_entries_used != want.used)
          report_mismatch("entries_used", out_entries_used, want.used);
        if (out_word_after != want.word)
          report_mismatch("word_after", out_word_after, want.word);
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == 2) begin
      out_stall <= ($urandom_range(99) < 66);
    end else if (idle_mode == 3) begin
      out_stall <= ($urandom_range(99) < 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    leaf_result_t typed_result;
    bit [sblf_pkg::ID_W-1:0] id;
    bit [sblf_pkg::KEY_W-1:0] hot_keys [16];
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_doc_id        = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_packed_limit = '0;
    errors           = 0;
    results_seen     = 0;
    ids_sent         = 0;
    idle_mode        = 0;
    hold_request     = 1'b0;
    hold_left        = 0;
    quiet_cycles     = 0;
    moved_dense      = 1'b0;
    leaf_limit       = 6'd32;
    leaf_dense       = 1'b0;
    leaf_count       = 0;
    for (int i = 0; i < sblf_pkg::DENSE_WORDS; i++) dense_store[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling.
    foreach (id_table[i]) begin
      typed_result.dense = id_table[i].dense;
      typed_result.used  = id_table[i].used;
      typed_result.word  = id_table[i].word;
      send_id(id_table[i].id, id_table[i].typed, typed_result);
    end

    // Packed phase: the highest limit lets the list reach its full depth, so
    // the move to the dense store comes from the full list. Most transfers hit
    // keys that are already present.
    write_limit(6'd63);
    for (int n = 0; n < 440; n++) begin
      if (n % 110 == 0) idle_mode = (n / 110) % 4;
      if (leaf_count < sblf_pkg::PACKED_DEPTH && $urandom_range(99) < 15)
        id = fresh_id();
      else
        id = {leaf_keys[$urandom_range(leaf_count - 1)], sblf_pkg::BIT_SHIFT'($urandom)};
      send_id(id, 1'b0, typed_result);
    end
    while (leaf_count < sblf_pkg::PACKED_DEPTH) send_id(fresh_id(), 1'b0, typed_result);
    send_id(fresh_id(), 1'b0, typed_result);

    // Dense phase. The limit is rewritten at its extremes and at random; the
    // mode must stay dense throughout.
    for (int k = 0; k < 16; k++) hot_keys[k] = sblf_pkg::KEY_W'($urandom);
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: write_limit(6'd0);
        3: write_limit(6'd63);
        default: write_limit(sblf_pkg::LIMIT_W'($urandom));
      endcase
      idle_mode = seg % 4;
      for (int n = 0; n < 250; n++) begin
        // Long hold-off on the result side while ids keep coming, so that
        // the unit fills up and stalls its input.
        if (seg == 1 && n == 20) hold_request = 1'b1;
        if ($urandom_range(99) < 50)
          id = {hot_keys[$urandom_range(15)], sblf_pkg::BIT_SHIFT'($urandom)};
        else
          id = sblf_pkg::ID_W'($urandom);
        send_id(id, 1'b0, typed_result);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ids and checked %0d results across idle and stall phases.",
             ids_sent, results_seen);
    $display("Packed list filled to its depth; move to dense store %s.",
             moved_dense ? "seen" : "not seen");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sblf_pkg.sv
rtl/sblf_ram.sv
rtl/sblf_cell.sv
rtl/sparse_bitmap_leaf_set_unit.sv
rtl/sblf_checker.sv
tb/sv/sparse_bitmap_leaf_set_unit_tb.sv
